// ===== design/rve_pkg.sv =====
package rve_pkg;

	localparam int FRAC = 14;
	localparam int CORDIC_STEPS = 16;
	localparam int ISQ_STEPS = 15;
	localparam int RAD_W = 29;
	localparam int ROOT_W = 15;
	localparam int QW = 20;
	localparam int CW = 23;
	localparam int ZW = 24;

	localparam logic [4:0] TAG_RESET = 5'd19;
	localparam logic signed [ZW-1:0] DEG90 = 24'sd2949120;
	localparam logic signed [15:0] LIM180 = 16'sd23040;
	localparam logic signed [15:0] LIM90 = 16'sd11520;
	localparam logic signed [33:0] ONE2 = 34'sd268435456;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [15:0] yaw;
		logic [14:0] scalar_part;
		logic pitch_clamped;
	} res_t;

	// atan(2^-i) in 1/32768 degree.
	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0: a = 24'sd1474560;
			1: a = 24'sd870484;
			2: a = 24'sd459940;
			3: a = 24'sd233473;
			4: a = 24'sd117189;
			5: a = 24'sd58652;
			6: a = 24'sd29333;
			7: a = 24'sd14667;
			8: a = 24'sd7334;
			9: a = 24'sd3667;
			10: a = 24'sd1833;
			11: a = 24'sd917;
			12: a = 24'sd458;
			13: a = 24'sd229;
			14: a = 24'sd115;
			15: a = 24'sd57;
			16: a = 24'sd29;
			17: a = 24'sd14;
			18: a = 24'sd7;
			19: a = 24'sd4;
			20: a = 24'sd2;
			21: a = 24'sd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Half float to Q1.14, round half away from zero, saturate.
	function automatic logic signed [15:0] half_to_fix(input logic [15:0] h);
		logic sgn;
		logic [4:0] e;
		logic [10:0] m;
		logic [31:0] mag;
		logic [11:0] rnd;
		int sh;
		sgn = h[15];
		e = h[14:10];
		m = {1'b0, h[9:0]};
		mag = '0;
		rnd = '0;
		sh = 0;
		if (e == 5'd31) begin
			mag = sgn ? 32'd32768 : 32'd32767;
		end else begin
			if (e == 5'd0) begin
				sh = 1 + FRAC - 25;
			end else begin
				m[10] = 1'b1;
				sh = int'(e) + FRAC - 25;
			end
			if (sh >= 0) begin
				mag = {21'b0, m} << sh;
			end else begin
				rnd = {1'b0, m} + (12'd1 << (-sh - 1));
				mag = {20'b0, rnd >> (-sh)};
			end
		end
		if (sgn) begin
			if (mag > 32'd32768) mag = 32'd32768;
			return -(mag[15:0]);
		end
		if (mag > 32'd32767) mag = 32'd32767;
		return mag[15:0];
	endfunction

	// Round a 2F-fraction term to F fraction bits, ties toward +infinity.
	function automatic logic signed [QW-1:0] to_qf(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = v + 34'sd8192;
		return t[33:14];
	endfunction

endpackage

// ===== design/rve_queue.sv =====
module rve_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [WIDTH-1:0] wr_data,
	output logic full,
	input logic rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;
	logic do_wr, do_rd;

	assign full = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end
endmodule

// ===== design/rve_front.sv =====
module rve_front import rve_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [4:0] tag_code,
	input logic [47:0] payload,
	input logic cfg_write,
	input logic [4:0] cfg_data,
	input logic q_full,
	output logic q_wr,
	output vec_t q_vec
);
	logic [4:0] rotation_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_tag_q <= TAG_RESET;
		end else if (cfg_write) begin
			rotation_tag_q <= cfg_data;
		end
	end

	// Words with another tag are taken and dropped here.
	assign q_wr = push && !q_full && (tag_code == rotation_tag_q);
	assign q_vec.x = half_to_fix(payload[15:0]);
	assign q_vec.y = half_to_fix(payload[31:16]);
	assign q_vec.z = half_to_fix(payload[47:32]);
endmodule

// ===== design/rve_isqrt.sv =====
module rve_isqrt import rve_pkg::*; (
	input logic clk,
	input logic en,
	input logic [RAD_W-1:0] rad,
	output logic [ROOT_W-1:0] root
);
	typedef struct packed {
		logic [RAD_W-1:0] v;
		logic [RAD_W-1:0] r;
	} isq_t;

	function automatic isq_t isq_step(input isq_t a, input int k);
		logic [RAD_W-1:0] b;
		logic [RAD_W:0] t;
		isq_t o;
		b = RAD_W'(1) << (RAD_W - 1 - 2 * k);
		t = {1'b0, a.r} + {1'b0, b};
		if ({1'b0, a.v} >= t) begin
			o.v = a.v - t[RAD_W-1:0];
			o.r = (a.r >> 1) + b;
		end else begin
			o.v = a.v;
			o.r = a.r >> 1;
		end
		return o;
	endfunction

	isq_t st_s [0:ISQ_STEPS-1];

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= isq_step('{v: rad, r: '0}, 0);
			for (int k = 1; k < ISQ_STEPS; k++) begin
				st_s[k] <= isq_step(st_s[k-1], k);
			end
		end
	end

	// Round to nearest: a remainder above the root means the next half step is passed.
	assign root = (st_s[ISQ_STEPS-1].v > st_s[ISQ_STEPS-1].r) ?
		ROOT_W'(st_s[ISQ_STEPS-1].r + 1'b1) : ROOT_W'(st_s[ISQ_STEPS-1].r);
endmodule

// ===== design/rve_cordic.sv =====
module rve_cordic import rve_pkg::*; (
	input logic clk,
	input logic en,
	input logic half_range,
	input logic signed [QW-1:0] y_in,
	input logic signed [QW-1:0] x_in,
	output logic signed [15:0] angle
);
	logic signed [CW-1:0] x_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] y_s [0:CORDIC_STEPS];
	logic signed [ZW-1:0] z_s [0:CORDIC_STEPS];
	logic zero_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] xi, yi, xp, yp;
	logic signed [ZW-1:0] zp, rz;
	logic signed [15:0] rr, lim;
	logic signed [15:0] angle_q;

	assign xi = {{(CW-QW){x_in[QW-1]}}, x_in};
	assign yi = {{(CW-QW){y_in[QW-1]}}, y_in};

	// Fold the left half plane onto the right one by a quarter turn.
	always_comb begin
		xp = xi;
		yp = yi;
		zp = '0;
		if (xi[CW-1]) begin
			if (!yi[CW-1]) begin
				xp = yi;
				yp = -xi;
				zp = DEG90;
			end else begin
				xp = -yi;
				yp = xi;
				zp = -DEG90;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= xp;
			y_s[0] <= yp;
			z_s[0] <= zp;
			zero_s[0] <= (x_in == '0) && (y_in == '0);
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + atan_entry(i);
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - atan_entry(i);
				end
			end
		end
	end

	assign rz = z_s[CORDIC_STEPS] + ZW'(128);
	assign rr = rz[ZW-1:8];
	assign lim = half_range ? LIM90 : LIM180;

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[CORDIC_STEPS]) angle_q <= '0;
			else if (rr > lim) angle_q <= lim;
			else if (rr < -lim) angle_q <= -lim;
			else angle_q <= rr;
		end
	end

	assign angle = angle_q;
endmodule

// ===== design/rve_back.sv =====
module rve_back import rve_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input vec_t in_vec,
	output logic in_pop,
	input logic out_full,
	output logic out_push,
	output res_t out_res
);
	localparam int D3 = CORDIC_STEPS + 2;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic signed [31:0] xy;
		logic signed [31:0] yz;
		logic signed [31:0] zx;
		logic signed [QW-1:0] cosr;
		logic signed [QW-1:0] cosy;
	} d1_t;

	typedef struct packed {
		logic signed [QW-1:0] sinr;
		logic signed [QW-1:0] siny;
		logic signed [QW-1:0] cosr;
		logic signed [QW-1:0] cosy;
		logic signed [15:0] s;
		logic clamp;
		logic neg;
		logic [ROOT_W-1:0] w;
	} d2_t;

	typedef struct packed {
		logic clamp;
		logic neg;
		logic [ROOT_W-1:0] w;
	} d3_t;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic v1_s [0:ISQ_STEPS-1];
	logic v2_s [0:ISQ_STEPS-1];
	logic v3_s [0:D3-1];

	vec_t vec_s1;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, yz_s1, zx_s1;
	logic [RAD_W-1:0] rad_s2;
	d1_t d1_s2;
	d1_t dly1_s [0:ISQ_STEPS-1];
	logic [ROOT_W-1:0] w1, w2;
	d1_t d1_s3;
	logic [ROOT_W-1:0] w_s3;
	logic signed [31:0] wx_s3, wy_s3, wz_s3;
	d2_t d2_s4, d2_s5;
	logic [RAD_W-1:0] rad_s5;
	d2_t dly2_s [0:ISQ_STEPS-1];
	d3_t dly3_s [0:D3-1];
	logic signed [15:0] roll_a, pitch_a, yaw_a;

	logic signed [33:0] sum2, cosr2, cosy2, sinr4, sinp4, siny4;
	logic signed [31:0] ssq5;
	d2_t d2_last;

	// The whole chain holds when the oldest word cannot enter the result queue.
	assign en = !(v3_s[D3-1] && out_full);
	assign in_pop = en && in_valid;
	assign out_push = en && v3_s[D3-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			for (int k = 0; k < ISQ_STEPS; k++) begin
				v1_s[k] <= 1'b0;
				v2_s[k] <= 1'b0;
			end
			for (int k = 0; k < D3; k++) v3_s[k] <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			v1_s[0] <= valid_s2;
			for (int k = 1; k < ISQ_STEPS; k++) v1_s[k] <= v1_s[k-1];
			valid_s3 <= v1_s[ISQ_STEPS-1];
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			v2_s[0] <= valid_s5;
			for (int k = 1; k < ISQ_STEPS; k++) v2_s[k] <= v2_s[k-1];
			v3_s[0] <= v2_s[ISQ_STEPS-1];
			for (int k = 1; k < D3; k++) v3_s[k] <= v3_s[k-1];
		end
	end

	always_comb begin
		sum2 = 34'(xx_s1) + 34'(yy_s1) + 34'(zz_s1);
		cosr2 = ONE2 - ((34'(xx_s1) + 34'(yy_s1)) <<< 1);
		cosy2 = ONE2 - ((34'(yy_s1) + 34'(zz_s1)) <<< 1);
		sinr4 = (34'(wx_s3) + 34'(d1_s3.yz)) <<< 1;
		sinp4 = (34'(wy_s3) - 34'(d1_s3.zx)) <<< 1;
		siny4 = (34'(wz_s3) + 34'(d1_s3.xy)) <<< 1;
		ssq5 = d2_s4.s * d2_s4.s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= in_vec;
			xx_s1 <= in_vec.x * in_vec.x;
			yy_s1 <= in_vec.y * in_vec.y;
			zz_s1 <= in_vec.z * in_vec.z;
			xy_s1 <= in_vec.x * in_vec.y;
			yz_s1 <= in_vec.y * in_vec.z;
			zx_s1 <= in_vec.z * in_vec.x;

			// A squared sum of one or more leaves w at zero.
			rad_s2 <= (sum2 >= ONE2) ? '0 : RAD_W'(ONE2 - sum2);
			d1_s2.x <= vec_s1.x;
			d1_s2.y <= vec_s1.y;
			d1_s2.z <= vec_s1.z;
			d1_s2.xy <= xy_s1;
			d1_s2.yz <= yz_s1;
			d1_s2.zx <= zx_s1;
			d1_s2.cosr <= to_qf(cosr2);
			d1_s2.cosy <= to_qf(cosy2);

			dly1_s[0] <= d1_s2;
			for (int k = 1; k < ISQ_STEPS; k++) dly1_s[k] <= dly1_s[k-1];

			d1_s3 <= dly1_s[ISQ_STEPS-1];
			w_s3 <= w1;
			wx_s3 <= $signed({1'b0, w1}) * dly1_s[ISQ_STEPS-1].x;
			wy_s3 <= $signed({1'b0, w1}) * dly1_s[ISQ_STEPS-1].y;
			wz_s3 <= $signed({1'b0, w1}) * dly1_s[ISQ_STEPS-1].z;

			d2_s4.sinr <= to_qf(sinr4);
			d2_s4.siny <= to_qf(siny4);
			d2_s4.cosr <= d1_s3.cosr;
			d2_s4.cosy <= d1_s3.cosy;
			d2_s4.s <= 16'(to_qf(sinp4));
			d2_s4.clamp <= (sinp4 >= ONE2) || (sinp4 <= -ONE2);
			d2_s4.neg <= sinp4[33];
			d2_s4.w <= w_s3;

			d2_s5 <= d2_s4;
			rad_s5 <= (34'(ssq5) >= ONE2) ? '0 : RAD_W'(ONE2 - 34'(ssq5));

			dly2_s[0] <= d2_s5;
			for (int k = 1; k < ISQ_STEPS; k++) dly2_s[k] <= dly2_s[k-1];

			dly3_s[0] <= '{clamp: d2_last.clamp, neg: d2_last.neg, w: d2_last.w};
			for (int k = 1; k < D3; k++) dly3_s[k] <= dly3_s[k-1];
		end
	end

	assign d2_last = dly2_s[ISQ_STEPS-1];

	rve_isqrt u_sqrt_w (
		.clk(clk),
		.en(en),
		.rad(rad_s2),
		.root(w1)
	);

	rve_isqrt u_sqrt_c (
		.clk(clk),
		.en(en),
		.rad(rad_s5),
		.root(w2)
	);

	rve_cordic u_roll (
		.clk(clk),
		.en(en),
		.half_range(1'b0),
		.y_in(d2_last.sinr),
		.x_in(d2_last.cosr),
		.angle(roll_a)
	);

	rve_cordic u_pitch (
		.clk(clk),
		.en(en),
		.half_range(1'b1),
		.y_in({{(QW-16){d2_last.s[15]}}, d2_last.s}),
		.x_in({{(QW-ROOT_W){1'b0}}, w2}),
		.angle(pitch_a)
	);

	rve_cordic u_yaw (
		.clk(clk),
		.en(en),
		.half_range(1'b0),
		.y_in(d2_last.siny),
		.x_in(d2_last.cosy),
		.angle(yaw_a)
	);

	always_comb begin
		out_res.roll = roll_a;
		out_res.yaw = yaw_a;
		out_res.scalar_part = dly3_s[D3-1].w;
		out_res.pitch_clamped = dly3_s[D3-1].clamp;
		if (dly3_s[D3-1].clamp) begin
			out_res.pitch = dly3_s[D3-1].neg ? 15'(-LIM90) : 15'(LIM90);
		end else begin
			out_res.pitch = pitch_a[14:0];
		end
	end
endmodule

// ===== design/rotation_vector_to_euler.sv =====
// Rotation vector to Euler angles: one FIFO word per cycle in while full is low, one result
// word per cycle out while empty is low and pop is high. The path runs through two 15-step
// square root pipelines in series and three parallel 18-stage CORDICs.
// Words whose tag differs from rotation_tag are accepted and give no result.
// Reset (arst_n low) empties both queues and the pipeline and sets rotation_tag to 19.
module rotation_vector_to_euler import rve_pkg::*; #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [4:0] tag_code,
	input logic [47:0] payload,
	input logic cfg_write,
	input logic [4:0] cfg_data,
	output logic empty,
	input logic pop,
	output logic signed [15:0] roll,
	output logic signed [14:0] pitch,
	output logic signed [15:0] yaw,
	output logic [14:0] scalar_part,
	output logic pitch_clamped
);
	logic q_wr, mid_empty, mid_pop, out_push, out_full;
	vec_t q_vec, mid_vec;
	res_t back_res, out_res;

	rve_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.tag_code(tag_code),
		.payload(payload),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.q_full(full),
		.q_wr(q_wr),
		.q_vec(q_vec)
	);

	rve_queue #(.WIDTH($bits(vec_t)), .DEPTH(MID_DEPTH)) u_mid_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(q_wr),
		.wr_data(q_vec),
		.full(full),
		.rd_en(mid_pop),
		.rd_data(mid_vec),
		.empty(mid_empty)
	);

	rve_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(!mid_empty),
		.in_vec(mid_vec),
		.in_pop(mid_pop),
		.out_full(out_full),
		.out_push(out_push),
		.out_res(back_res)
	);

	rve_queue #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(out_push),
		.wr_data(back_res),
		.full(out_full),
		.rd_en(pop),
		.rd_data(out_res),
		.empty(empty)
	);

	assign roll = out_res.roll;
	assign pitch = out_res.pitch;
	assign yaw = out_res.yaw;
	assign scalar_part = out_res.scalar_part;
	assign pitch_clamped = out_res.pitch_clamped;
endmodule

// ===== dv/tb_rotation_vector_to_euler.sv =====
`timescale 1ns / 100ps

module tb_rotation_vector_to_euler;
	import rve_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [4:0] tag_code = '0;
	logic [47:0] payload = '0;
	logic cfg_write = 1'b0;
	logic [4:0] cfg_data = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [15:0] roll;
	logic signed [14:0] pitch;
	logic signed [15:0] yaw;
	logic [14:0] scalar_part;
	logic pitch_clamped;

	rotation_vector_to_euler dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.tag_code(tag_code),
		.payload(payload),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.empty(empty),
		.pop(pop),
		.roll(roll),
		.pitch(pitch),
		.yaw(yaw),
		.scalar_part(scalar_part),
		.pitch_clamped(pitch_clamped)
	);

	localparam longint ONE_F = 64'sd1 << 14;
	localparam longint ONE_2F = 64'sd1 << 28;
	localparam longint ANGLE_90 = 64'sd90 * 128 * 256;

	typedef struct {
		logic [4:0] tag;
		logic [47:0] data;
	} fifo_word_t;

	longint arctan_steps[24] = '{1474560, 870484, 459940, 233473, 117189, 58652, 29333,
		14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0};

	res_t angle_queue[$];
	logic [4:0] tag_mirror = TAG_RESET;
	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Timeout waiting for results");
		$display("Mismatches found");
		$finish;
	end

	function automatic longint half_to_q14(logic [15:0] h);
		longint mant, mag;
		int e, sh;
		e = h[14:10];
		mant = h[9:0];
		if (e == 31) begin
			mag = h[15] ? 32768 : 32767;
		end else begin
			if (e == 0) begin
				sh = 1 + 14 - 25;
			end else begin
				mant = mant | 1024;
				sh = e + 14 - 25;
			end
			if (sh >= 0) mag = mant << sh;
			else mag = (mant + (64'sd1 << (-sh - 1))) >>> (-sh);
		end
		if (h[15]) begin
			if (mag > 32768) mag = 32768;
			return -mag;
		end
		if (mag > 32767) mag = 32767;
		return mag;
	endfunction

	function automatic longint root_nearest(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (v > r) r++;
		return longint'(r);
	endfunction

	function automatic longint round_q14(longint v);
		return (v + 8192) >>> 14;
	endfunction

	function automatic longint vector_angle(longint ys, longint xs, longint lim);
		longint za, t, dx, dy, r;
		za = 0;
		if (xs == 0 && ys == 0) return 0;
		if (xs < 0) begin
			t = xs;
			if (ys >= 0) begin
				xs = ys;
				ys = -t;
				za = ANGLE_90;
			end else begin
				xs = -ys;
				ys = t;
				za = -ANGLE_90;
			end
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = ys >>> i;
			dy = xs >>> i;
			if (ys >= 0) begin
				xs += dx;
				ys -= dy;
				za += arctan_steps[i];
			end else begin
				xs -= dx;
				ys += dy;
				za -= arctan_steps[i];
			end
		end
		r = (za + 128) >>> 8;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r;
	endfunction

	function automatic res_t euler_of(logic [47:0] p);
		longint qx, qy, qz, qw, sq, sinr, cosr, sinp, siny, cosy, s, rem, c, pt;
		res_t o;
		qx = half_to_q14(p[15:0]);
		qy = half_to_q14(p[31:16]);
		qz = half_to_q14(p[47:32]);
		sq = qx * qx + qy * qy + qz * qz;
		qw = (sq < ONE_2F) ? root_nearest(ONE_2F - sq) : 0;
		sinr = 2 * (qw * qx + qy * qz);
		cosr = ONE_2F - 2 * (qx * qx + qy * qy);
		sinp = 2 * (qw * qy - qz * qx);
		siny = 2 * (qw * qz + qx * qy);
		cosy = ONE_2F - 2 * (qy * qy + qz * qz);
		o.pitch_clamped = 1'b0;
		if (sinp >= ONE_2F || sinp <= -ONE_2F) begin
			pt = sinp > 0 ? 11520 : -11520;
			o.pitch_clamped = 1'b1;
		end else begin
			s = round_q14(sinp);
			rem = ONE_F * ONE_F - s * s;
			c = rem > 0 ? root_nearest(rem) : 0;
			pt = vector_angle(s, c, 11520);
		end
		o.roll = 16'(vector_angle(round_q14(sinr), round_q14(cosr), 23040));
		o.pitch = 15'(pt);
		o.yaw = 16'(vector_angle(round_q14(siny), round_q14(cosy), 23040));
		o.scalar_part = 15'(qw);
		return o;
	endfunction

	// Accepted words and results are both sampled on the pre-edge values.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (push && !full) begin
				words_sent++;
				if (tag_code == tag_mirror) angle_queue.push_back(euler_of(payload));
			end
			if (pop && !empty) begin
				results_seen++;
				if (angle_queue.size() == 0) begin
					$error("Result word with nothing expected");
					errors++;
				end else begin
					want = angle_queue.pop_front();
					if (roll !== want.roll) begin
						$error("roll: expected %0d, got %0d", want.roll, roll);
						errors++;
					end
					if (pitch !== want.pitch) begin
						$error("pitch: expected %0d, got %0d", want.pitch, pitch);
						errors++;
					end
					if (yaw !== want.yaw) begin
						$error("yaw: expected %0d, got %0d", want.yaw, yaw);
						errors++;
					end
					if (scalar_part !== want.scalar_part) begin
						$error("scalar_part: expected %0d, got %0d", want.scalar_part,
							scalar_part);
						errors++;
					end
					if (pitch_clamped !== want.pitch_clamped) begin
						$error("pitch_clamped: expected %0d, got %0d", want.pitch_clamped,
							pitch_clamped);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_word(logic [4:0] t, logic [47:0] d);
		int gap;
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		tag_code <= t;
		payload <= d;
		do @(posedge clk); while (full);
	endtask

	task automatic drain_and_settle();
		push <= 1'b0;
		while (angle_queue.size() != 0) @(posedge clk);
		// Words with a foreign tag are dropped at the front and never enter the pipeline.
		repeat (80) @(posedge clk);
	endtask

	task automatic set_rotation_tag(logic [4:0] v);
		drain_and_settle();
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		tag_mirror = v;
	endtask

	function automatic logic [15:0] random_half();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return {1'($urandom), 5'($urandom_range(0, 13)), 10'($urandom)};
		if (pick < 85) return {1'($urandom), 5'($urandom_range(13, 15)), 10'($urandom)};
		if (pick < 95) return 16'($urandom);
		return {1'($urandom), 5'd31, 10'($urandom_range(0, 1) * $urandom)};
	endfunction

	task automatic random_phase(int count);
		logic [4:0] t;
		for (int i = 0; i < count; i++) begin
			t = ($urandom_range(99) < 80) ? tag_mirror : 5'($urandom);
			send_word(t, {random_half(), random_half(), random_half()});
		end
	endtask

	// Payload is z, y, x from the top; expected results follow from the tag alone
	// only for foreign-tag rows, the rest go through euler_of.
	fifo_word_t directed_words[] = '{
		'{5'd19, 48'h0000_0000_0000},
		'{5'd19, 48'h0000_0000_3C00},
		'{5'd19, 48'h0000_3C00_0000},
		'{5'd19, 48'h3C00_0000_0000},
		'{5'd19, 48'hBC00_BC00_BC00},
		'{5'd19, 48'h7BFF_FBFF_7BFF},
		'{5'd19, 48'h7C00_FC00_7C00},
		'{5'd19, 48'hFE00_7E00_FC00},
		'{5'd19, 48'h8001_0001_8001},
		'{5'd19, 48'h03FF_83FF_0400},
		'{5'd19, 48'h0000_3800_3800},
		'{5'd19, 48'h39A8_0000_B9A8},
		'{5'd19, 48'hB9A8_0000_B9A8},
		'{5'd19, 48'h0000_39A8_0000},
		'{5'd19, 48'h3400_3400_3400},
		'{5'd19, 48'hFFFF_FFFF_FFFF},
		'{5'd19, 48'h3555_B555_2E66},
		'{5'd18, 48'h3C00_3C00_3C00},
		'{5'd0, 48'hFFFF_FFFF_FFFF},
		'{5'd31, 48'h0000_0000_0000}
	};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[i]) send_word(directed_words[i].tag, directed_words[i].data);

		send_idle_pct = 28;
		recv_idle_pct = 88;
		random_phase(350);
		set_rotation_tag(5'd0);
		send_idle_pct = 88;
		recv_idle_pct = 28;
		random_phase(350);
		set_rotation_tag(5'd31);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(175);
		set_rotation_tag(5'($urandom));
		random_phase(175);

		drain_and_settle();
		$display("Sent %0d words through four tag settings and three stall patterns;",
			words_sent);
		$display("checked %0d angle results against the predictor.", results_seen);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
